// ===== rtl/s2c_pkg.sv =====
// shared types and constants for the scalar to colormap mapper
package s2c_pkg;

  localparam int VW = 37;
  localparam int QW = 16;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW = 5;
  localparam int CNT_W = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP = 1'b1;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_RANGE_LOW = 3'd1;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd2;
  localparam logic [2:0] REG_INVERT = 3'd3;
  localparam logic [2:0] REG_TOP_INDEX = 3'd4;

  localparam logic [16:0] LVL_ONE = 17'h10000;
  localparam logic [16:0] LVL_HALF = 17'h08000;

  typedef enum logic [1:0] {
    MODE_TRUE,
    MODE_SYMMETRIC,
    MODE_SEPARATE,
    MODE_MIDPOINT
  } map_mode_t;

  typedef logic signed [VW-1:0] sval_t;

  typedef struct packed {
    logic        valid;
    logic        is_map;
    logic [7:0]  widx;
    logic [23:0] wcolor;
  } tag_t;

  typedef struct packed {
    tag_t          tag;
    logic          mirror;
    logic          half;
    logic          zero;
    logic          full;
    logic          dpos;
    logic [VW-1:0] rem;
    logic [VW-1:0] den;
    logic [QW-1:0] quo;
  } div_job_t;

  function automatic sval_t dbl(input logic [31:0] x);
    return {{(VW-33){x[31]}}, x, 1'b0};
  endfunction

  function automatic sval_t sext(input logic [31:0] x);
    return {{(VW-32){x[31]}}, x};
  endfunction

endpackage

// ===== rtl/s2c_ram.sv =====
// generic single clock ram with registered read
module s2c_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/s2c_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module s2c_div (
  input  logic              clk,
  input  logic              rst_n,
  input  s2c_pkg::div_job_t job_in,
  output s2c_pkg::div_job_t job_out
);

  s2c_pkg::div_job_t st_r [s2c_pkg::QW];

  function automatic s2c_pkg::div_job_t step(input s2c_pkg::div_job_t j);
    s2c_pkg::div_job_t   n;
    logic [s2c_pkg::VW:0] r2;
    logic [s2c_pkg::VW:0] d2;
    logic                 ge;
    n = j;
    r2 = {j.rem, 1'b0};
    d2 = {1'b0, j.den};
    ge = j.dpos && (r2 >= d2);
    n.rem = ge ? s2c_pkg::VW'(r2 - d2) : s2c_pkg::VW'(r2);
    n.quo = {j.quo[s2c_pkg::QW-2:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < s2c_pkg::QW; k++) begin
        st_r[k].tag.valid <= 1'b0;
      end
    end else begin
      st_r[0] <= step(job_in);
      for (int k = 1; k < s2c_pkg::QW; k++) begin
        st_r[k] <= step(st_r[k-1]);
      end
    end
  end

  assign job_out = st_r[s2c_pkg::QW-1];

endmodule

// ===== rtl/scalar_to_colormap_mapper.sv =====
// top level of the scalar to colormap mapper
// throughput: one item per cycle while in_ready is high, set by a fully pipelined 16-stage divider
// and a color table read or written once per cycle
// in_ready drops only when 32 map results are in flight or queued
// synchronous active-low reset clears control and config; table is not cleared
module scalar_to_colormap_mapper #(
  parameter int COLOR_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_sample_value,
  input  logic [7:0]  in_entry_index,
  input  logic [23:0] in_entry_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [16:0] out_level,
  output logic [7:0]  out_color_index
);

  localparam int AW = $clog2(COLOR_ENTRIES);
  localparam int FW = 24 + 17 + 8;

  s2c_pkg::map_mode_t mode_r;
  logic [31:0]        range_low_r;
  logic [31:0]        range_high_r;
  logic               invert_r;
  logic [7:0]         top_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= s2c_pkg::MODE_TRUE;
      range_low_r <= 32'd0;
      range_high_r <= 32'd65536;
      invert_r <= 1'b0;
      top_index_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        s2c_pkg::REG_MODE:       mode_r <= s2c_pkg::map_mode_t'(cfg_data[1:0]);
        s2c_pkg::REG_RANGE_LOW:  range_low_r <= cfg_data;
        s2c_pkg::REG_RANGE_HIGH: range_high_r <= cfg_data;
        s2c_pkg::REG_INVERT:     invert_r <= cfg_data[0];
        s2c_pkg::REG_TOP_INDEX:  top_index_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // credits
  logic                    in_fire;
  logic                    pop;
  logic [s2c_pkg::CNT_W-1:0] cnt_r;
  logic [s2c_pkg::CNT_W-1:0] cnt_nxt;

  assign in_ready = (cnt_r < s2c_pkg::CNT_W'(s2c_pkg::FIFO_DEPTH));
  assign in_fire = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire && (in_command == s2c_pkg::CMD_MAP)) begin
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // stage a: fold by mode
  s2c_pkg::tag_t a_tag_nxt;
  s2c_pkg::tag_t a_tag_r;
  logic          a_mir_nxt, a_mir_r;
  logic          a_half_nxt, a_half_r;
  s2c_pkg::sval_t a_p_nxt, a_lo_nxt, a_hi_nxt;
  s2c_pkg::sval_t a_p_r, a_lo_r, a_hi_r;
  s2c_pkg::sval_t p2, lo2, hi2, mid, m1;

  always_comb begin
    a_tag_nxt.valid = in_fire;
    a_tag_nxt.is_map = (in_command == s2c_pkg::CMD_MAP);
    a_tag_nxt.widx = in_entry_index;
    a_tag_nxt.wcolor = in_entry_color;
    p2 = s2c_pkg::dbl(in_sample_value);
    lo2 = s2c_pkg::dbl(range_low_r);
    hi2 = s2c_pkg::dbl(range_high_r);
    mid = s2c_pkg::sext(range_low_r) + s2c_pkg::sext(range_high_r);
    m1 = (hi2 > -lo2) ? hi2 : -lo2;
    a_mir_nxt = 1'b0;
    a_half_nxt = 1'b1;
    a_p_nxt = p2;
    a_lo_nxt = '0;
    a_hi_nxt = hi2;
    unique case (mode_r)
      s2c_pkg::MODE_TRUE: begin
        a_half_nxt = 1'b0;
        a_lo_nxt = lo2;
      end
      s2c_pkg::MODE_SYMMETRIC: begin
        a_hi_nxt = m1;
        if (p2 < 0) begin
          a_mir_nxt = 1'b1;
          a_p_nxt = -p2;
          a_hi_nxt = (m1 > 0) ? m1 : '0;
        end
      end
      s2c_pkg::MODE_SEPARATE: begin
        if (p2 < 0) begin
          a_mir_nxt = 1'b1;
          a_p_nxt = -p2;
          a_hi_nxt = -lo2;
        end
      end
      s2c_pkg::MODE_MIDPOINT: begin
        a_lo_nxt = mid;
        if (p2 < mid) begin
          a_mir_nxt = 1'b1;
          a_p_nxt = (mid <<< 1) - p2;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.valid <= 1'b0;
    end else begin
      a_tag_r <= a_tag_nxt;
    end
    a_mir_r <= a_mir_nxt;
    a_half_r <= a_half_nxt;
    a_p_r <= a_p_nxt;
    a_lo_r <= a_lo_nxt;
    a_hi_r <= a_hi_nxt;
  end

  // stage b: clamp and width
  s2c_pkg::tag_t  b_tag_r;
  logic           b_mir_r, b_half_r;
  s2c_pkg::sval_t b_pc_r, b_lo_r, b_den_r;
  s2c_pkg::sval_t pc_hi, pc_nxt;

  always_comb begin
    pc_hi = (a_p_r > a_hi_r) ? a_hi_r : a_p_r;
    pc_nxt = (pc_hi < a_lo_r) ? a_lo_r : pc_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r.valid <= 1'b0;
    end else begin
      b_tag_r <= a_tag_r;
    end
    b_mir_r <= a_mir_r;
    b_half_r <= a_half_r;
    b_pc_r <= pc_nxt;
    b_lo_r <= a_lo_r;
    b_den_r <= a_hi_r - a_lo_r;
  end

  // divider
  s2c_pkg::div_job_t job_in;
  s2c_pkg::div_job_t job_out;
  s2c_pkg::sval_t    num;

  always_comb begin
    num = b_pc_r - b_lo_r;
    job_in.tag = b_tag_r;
    job_in.mirror = b_mir_r;
    job_in.half = b_half_r;
    job_in.dpos = (b_den_r > 0);
    job_in.zero = (b_den_r == 0);
    job_in.full = job_in.dpos && (num == b_den_r);
    job_in.rem = num;
    job_in.den = b_den_r;
    job_in.quo = '0;
  end

  s2c_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_in (job_in),
    .job_out(job_out)
  );

  // stage d: level
  s2c_pkg::tag_t d_tag_r;
  logic [16:0]   d_lvl_r;
  logic [16:0]   frac;
  logic [16:0]   lvl_nxt;

  always_comb begin
    frac = job_out.full ? s2c_pkg::LVL_ONE : {1'b0, job_out.quo};
    if (job_out.half) begin
      frac = frac >> 1;
    end
    lvl_nxt = (job_out.half ? s2c_pkg::LVL_HALF : 17'd0) + frac;
    if (invert_r) begin
      lvl_nxt = s2c_pkg::LVL_ONE - lvl_nxt;
    end
    if (job_out.zero) begin
      lvl_nxt = '0;
    end
    if (job_out.mirror) begin
      lvl_nxt = s2c_pkg::LVL_ONE - lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_tag_r.valid <= 1'b0;
    end else begin
      d_tag_r <= job_out.tag;
    end
    d_lvl_r <= lvl_nxt;
  end

  // stage e: index multiply
  s2c_pkg::tag_t e_tag_r;
  logic [16:0]   e_lvl_r;
  logic [7:0]    e_idx_r;
  logic [24:0]   prod;

  assign prod = top_index_r * d_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_tag_r.valid <= 1'b0;
    end else begin
      e_tag_r <= d_tag_r;
    end
    e_lvl_r <= d_lvl_r;
    e_idx_r <= prod[23:16];
  end

  // table access
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0]   ram_rdata;
  logic [7:0]    sat_idx;
  logic          f_valid_r;
  logic [16:0]   f_lvl_r;
  logic [7:0]    f_idx_r;

  always_comb begin
    if (32'(e_idx_r) >= 32'(COLOR_ENTRIES)) begin
      sat_idx = 8'(COLOR_ENTRIES - 1);
    end else begin
      sat_idx = e_idx_r;
    end
    ram_re = e_tag_r.valid && e_tag_r.is_map;
    ram_we = e_tag_r.valid && !e_tag_r.is_map &&
             (32'(e_tag_r.widx) < 32'(COLOR_ENTRIES));
    ram_raddr = AW'(sat_idx);
    ram_waddr = AW'(e_tag_r.widx);
  end

  s2c_ram #(
    .WIDTH(24),
    .DEPTH(COLOR_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(e_tag_r.wcolor),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= ram_re;
    end
    f_lvl_r <= e_lvl_r;
    f_idx_r <= sat_idx;
  end

  // result queue
  logic [FW-1:0]               fifo_r [s2c_pkg::FIFO_DEPTH];
  logic [s2c_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [s2c_pkg::CNT_W-1:0]   fill_r;
  logic [s2c_pkg::CNT_W-1:0]   fill_nxt;
  logic [FW-1:0]               head;

  always_comb begin
    fill_nxt = fill_r;
    if (f_valid_r) begin
      fill_nxt = fill_nxt + 1'b1;
    end
    if (pop) begin
      fill_nxt = fill_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (f_valid_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (f_valid_r) begin
      fifo_r[wr_ptr_r] <= {ram_rdata, f_lvl_r, f_idx_r};
    end
  end

  assign head = fifo_r[rd_ptr_r];
  assign out_valid = (fill_r != '0);
  assign out_red = head[48:41];
  assign out_green = head[40:33];
  assign out_blue = head[32:25];
  assign out_level = head[24:8];
  assign out_color_index = head[7:0];

endmodule

// ===== rtl/s2c_checker.sv =====
// port-level checks for the scalar to colormap mapper
module s2c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic [31:0] in_sample_value,
  input logic [7:0]  in_entry_index,
  input logic [23:0] in_entry_color,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [16:0] out_level,
  input logic [7:0]  out_color_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_level) && $stable(out_color_index))
    else $error("stalled result changed");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= 17'h10000)
    else $error("level above one");

  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind scalar_to_colormap_mapper s2c_checker u_s2c_checker (.*);
